// ----- hw/rtl/rtfd_pkg.sv -----
// ----------------------------------------------------------------------------
// rtfd_pkg
// Shared types, constants and tables for the radar target frame decoder.
// ----------------------------------------------------------------------------
package rtfd_pkg;

  localparam int FrameLen       = 14;
  localparam int AngleIterDef   = 14;
  localparam int AngleIterMax   = 20;

  localparam logic [7:0] ByteStart   = 8'hAA;
  localparam logic [7:0] ByteEnd     = 8'h55;
  localparam logic [7:0] ByteClass   = 8'h06;
  localparam logic [7:0] ByteTarget  = 8'h0b;
  localparam logic [7:0] ByteEndScan = 8'h0a;

  localparam logic       KindTarget  = 1'b0;
  localparam logic       KindEndScan = 1'b1;

  // angle accumulator: radians in units of 2^-24
  localparam int AccW = 28;
  localparam logic signed [AccW-1:0] PiQ24   = 28'sd52707179;
  localparam logic signed [15:0]     AzLimit = 16'sd25736;

  // cordic vector: position scaled by 2^20, plus growth headroom
  localparam int VecW = 36;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_ANGLE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;      // capture a finished frame
    logic step;      // one root bit pair and one cordic step
    logic finish;    // form the output word
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic angle_done;
    logic at_last;   // next byte completes a frame
  } sts_t;

  function automatic logic signed [AccW-1:0] atan_q24(input logic [4:0] idx);
    logic signed [AccW-1:0] v;
    unique case (idx)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/rtfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// rtfd_ctrl
// Sequencer: starts root and angle iterations for a captured frame and
// holds the result until the output transfer.
// ----------------------------------------------------------------------------
module rtfd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          frame_ok_i,   // a frame yielding a result completes
  input  logic          frame_tgt_i,  // that frame is a target report
  input  rtfd_pkg::sts_t sts_i,
  input  logic          out_ready_i,
  output rtfd_pkg::cmd_t cmd_o,
  output logic          in_ready_o,
  output logic          out_valid_o
);
  import rtfd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (frame_ok_i) begin
          cmd_o.load = 1'b1;
          state_d = frame_tgt_i ? ST_ROOT : ST_OUT;
        end
      end
      ST_ROOT: begin
        cmd_o.step = 1'b1;
        if (sts_i.root_done) state_d = ST_ANGLE;
      end
      ST_ANGLE: begin
        cmd_o.step = 1'b1;
        if (sts_i.angle_done) begin
          cmd_o.finish = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        // bytes keep flowing, only the frame-completing one waits
        in_ready_o  = out_ready_i || !sts_i.at_last;
        if (out_ready_i) begin
          state_d = ST_IDLE;
          if (frame_ok_i) begin
            cmd_o.load = 1'b1;
            state_d = frame_tgt_i ? ST_ROOT : ST_OUT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/rtfd_dp.sv -----
// ----------------------------------------------------------------------------
// rtfd_dp
// Datapath: frame store, field extraction, two bit-serial square roots and
// an iterative vectoring cordic, plus the output register.
// ----------------------------------------------------------------------------
module rtfd_dp #(
  parameter int AngleIter = rtfd_pkg::AngleIterDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  byte_en_i,   // input transfer
  input  logic [7:0]            rx_byte_i,
  input  rtfd_pkg::cmd_t        cmd_i,
  output rtfd_pkg::sts_t        sts_o,
  output logic                  frame_ok_o,
  output logic                  frame_tgt_o,
  output logic                  result_kind_o,
  output logic [7:0]            target_id_o,
  output logic signed [13:0]    pos_forward_o,
  output logic signed [10:0]    pos_left_o,
  output logic signed [9:0]     vel_forward_o,
  output logic signed [9:0]     vel_left_o,
  output logic [12:0]           target_range_o,
  output logic [9:0]            target_speed_o,
  output logic signed [15:0]    azimuth_o
);
  import rtfd_pkg::*;

  localparam int NIter = (AngleIter > AngleIterMax) ? AngleIterMax : AngleIter;

  // ---- framing ----
  logic [7:0] fb_q [FrameLen-1];   // bytes 0..12, byte 13 is the live byte
  logic [3:0] pos_q;
  logic       last;

  assign last = byte_en_i && (pos_q == 4'(FrameLen-1));
  assign sts_o.at_last = (pos_q == 4'(FrameLen-1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (byte_en_i) begin
      if (last) pos_q <= '0;
      else if (rx_byte_i == ByteStart || pos_q != '0) pos_q <= pos_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_en_i && !last) fb_q[pos_q] <= rx_byte_i;
  end

  logic frame_good;
  assign frame_good  = last && rx_byte_i == ByteEnd && fb_q[12] == ByteEnd &&
                       fb_q[3] == ByteClass;
  assign frame_tgt_o = fb_q[2] == ByteTarget;
  assign frame_ok_o  = frame_good && (fb_q[2] == ByteTarget || fb_q[2] == ByteEndScan);

  // ---- field extraction ----
  logic signed [13:0] fwd_c;
  logic signed [10:0] left_c;
  logic signed [9:0]  vf_c, vl_c;
  assign fwd_c  = 14'($signed({1'b0, fb_q[5], fb_q[6][7:3]}) - 15'sd5000);
  assign left_c = 11'($signed(12'sd1023) - $signed({1'b0, fb_q[6][2:0], fb_q[7]}));
  assign vf_c   = 10'($signed({1'b0, fb_q[8], fb_q[9][7:6]}) - 11'sd512);
  assign vl_c   = 10'($signed(11'sd256) - $signed({1'b0, fb_q[9][5:0], fb_q[10][7:5]}));

  // ---- held fields ----
  logic [7:0]         id_q;
  logic signed [13:0] fwd_q;
  logic signed [10:0] left_q;
  logic signed [9:0]  vf_q, vl_q;

  // ---- square roots, one bit pair a step ----
  logic [25:0] rv_q, rres_q, rbit_q;   // range radicand < 2^26
  logic [19:0] sv_q, sres_q, sbit_q;   // speed radicand < 2^20
  logic [26:0] rsum;
  logic [20:0] ssum;
  assign rsum = {1'b0, rres_q} + {1'b0, rbit_q};
  assign ssum = {1'b0, sres_q} + {1'b0, sbit_q};
  assign sts_o.root_done = (rbit_q[1:0] == 2'b01 || rbit_q == '0) &&
                           (sbit_q[1:0] == 2'b01 || sbit_q == '0) &&
                           !(rbit_q != '0 && rbit_q[25:2] != '0) &&
                           !(sbit_q != '0 && sbit_q[19:2] != '0);

  // ---- cordic ----
  logic signed [VecW-1:0] x_q, y_q;
  logic signed [AccW-1:0] z_q;
  logic [4:0]             it_q;
  logic                   az_fix_q;   // left == 0 case
  logic signed [15:0]     az_fix_val_q;
  logic signed [VecW-1:0] dx, dy;
  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign sts_o.angle_done = (it_q == 5'(NIter-1)) || az_fix_q;

  logic [27:0] r_sq;
  logic [20:0] s_sq;
  logic signed [27:0] fsq, lsq;
  logic signed [19:0] vfsq, vlsq;
  assign fsq  = 28'(fwd_c) * 28'(fwd_c);
  assign lsq  = 28'(left_c) * 28'(left_c);
  assign vfsq = 20'(vf_c) * 20'(vf_c);
  assign vlsq = 20'(vl_c) * 20'(vl_c);
  assign r_sq = 28'(fsq) + 28'(lsq);
  assign s_sq = 21'(vfsq) + 21'(vlsq);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= frame_tgt_o ? fb_q[4] : 8'd0;
      fwd_q  <= frame_tgt_o ? fwd_c : '0;
      left_q <= frame_tgt_o ? left_c : '0;
      vf_q   <= frame_tgt_o ? vf_c : '0;
      vl_q   <= frame_tgt_o ? vl_c : '0;
      rv_q   <= r_sq[25:0];
      rres_q <= '0;
      rbit_q <= 26'h1000000;
      sv_q   <= s_sq[19:0];
      sres_q <= '0;
      sbit_q <= 20'h40000;
      it_q   <= '0;
      az_fix_q     <= (left_c == '0);
      az_fix_val_q <= (fwd_c < 0) ? AzLimit : '0;
      if (fwd_c < 0) begin
        x_q <= -(VecW'(fwd_c) <<< 20);
        y_q <= -(VecW'(left_c) <<< 20);
        z_q <= (left_c > 0) ? PiQ24 : -PiQ24;
      end else begin
        x_q <= VecW'(fwd_c) <<< 20;
        y_q <= VecW'(left_c) <<< 20;
        z_q <= '0;
      end
    end else if (cmd_i.step) begin
      if (rbit_q != '0) begin
        if (rsum <= {1'b0, rv_q}) begin
          rv_q   <= rv_q - rsum[25:0];
          rres_q <= (rres_q >> 1) + rbit_q;
        end else begin
          rres_q <= rres_q >> 1;
        end
        rbit_q <= rbit_q >> 2;
      end
      if (sbit_q != '0) begin
        if (ssum <= {1'b0, sv_q}) begin
          sv_q   <= sv_q - ssum[19:0];
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      if (sts_o.root_done && !az_fix_q) begin
        it_q <= it_q + 5'd1;
        if (y_q >= 0) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_q24(it_q);
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_q24(it_q);
        end
      end
    end
  end

  // final cordic step folded into the output register
  logic signed [AccW-1:0] zl;
  logic signed [AccW-1:0] zlr;
  logic signed [AccW-12:0] zls;
  assign zl  = (y_q >= 0) ? z_q + atan_q24(it_q) : z_q - atan_q24(it_q);
  assign zlr = zl + AccW'(1024);
  assign zls = zlr[AccW-1:11];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_kind_o <= 1'b0;
    end else if (cmd_i.load) begin
      result_kind_o <= frame_tgt_o ? KindTarget : KindEndScan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !frame_tgt_o) begin
      target_id_o    <= '0;
      pos_forward_o  <= '0;
      pos_left_o     <= '0;
      vel_forward_o  <= '0;
      vel_left_o     <= '0;
      target_range_o <= '0;
      target_speed_o <= '0;
      azimuth_o      <= '0;
    end else if (cmd_i.finish) begin
      target_id_o    <= id_q;
      pos_forward_o  <= fwd_q;
      pos_left_o     <= left_q;
      vel_forward_o  <= vf_q;
      vel_left_o     <= vl_q;
      target_range_o <= rres_q[12:0];
      target_speed_o <= sres_q[9:0];
      if (az_fix_q) azimuth_o <= az_fix_val_q;
      else if (zls > AzLimit) azimuth_o <= AzLimit;
      else if (zls < -AzLimit) azimuth_o <= -AzLimit;
      else azimuth_o <= zls[15:0];
    end
  end

endmodule

// ----- hw/rtl/radar_target_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// radar_target_frame_decoder
// Gathers 14-byte radar frames and reports targets and end-of-scan markers.
// ----------------------------------------------------------------------------
// Input channel: one serial byte per transfer (rx_byte_i, valid/ready).
// Output channel: one result per complete valid frame (valid/ready); frames
// with a bad tail or an unknown class give nothing.
// Framing takes one byte per cycle. After the last byte of a target frame the
// input stalls through 13 root steps (range and speed together, the last one
// also running the first cordic step), then ANGLE_ITERATIONS - 1 cordic
// steps, the final one folded into the output register. With a zero left
// position the angle is fixed and no cordic step runs. An end-of-scan marker
// is valid the cycle after its last byte, no stall.
// While a result waits on out_ready_i, bytes keep flowing; only the byte
// that would complete the next frame waits until the result leaves.
// Reset clears the byte counter and the sequencer; the block then hunts for
// a start byte.
// ----------------------------------------------------------------------------
module radar_target_frame_decoder #(
  parameter int ANGLE_ITERATIONS = rtfd_pkg::AngleIterDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic [7:0]         target_id_o,
  output logic signed [13:0] pos_forward_o,
  output logic signed [10:0] pos_left_o,
  output logic signed [9:0]  vel_forward_o,
  output logic signed [9:0]  vel_left_o,
  output logic [12:0]        target_range_o,
  output logic [9:0]         target_speed_o,
  output logic signed [15:0] azimuth_o
);
  import rtfd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic frame_ok, frame_tgt, byte_en;

  assign byte_en = in_valid_i && in_ready_o;

  rtfd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .frame_ok_i  (frame_ok && byte_en),
    .frame_tgt_i (frame_tgt),
    .sts_i       (sts),
    .out_ready_i,
    .cmd_o       (cmd),
    .in_ready_o,
    .out_valid_o
  );

  rtfd_dp #(.AngleIter(ANGLE_ITERATIONS)) u_dp (
    .clk_i, .rst_ni,
    .byte_en_i   (byte_en),
    .rx_byte_i,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .frame_ok_o  (frame_ok),
    .frame_tgt_o (frame_tgt),
    .result_kind_o, .target_id_o, .pos_forward_o, .pos_left_o,
    .vel_forward_o, .vel_left_o, .target_range_o, .target_speed_o, .azimuth_o
  );

endmodule
